// ----- hdl/fdm_pkg.sv -----
// ----------------------------------------------------------------------------
// fdm_pkg
// Shared types and constants for the floored divide / modulo core.
// ----------------------------------------------------------------------------
package fdm_pkg;

  // fixed width of every data field on the ports
  localparam int unsigned DATA_W    = 64;
  // default operand width used for the arithmetic
  localparam int unsigned WIDTH_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] dividend;
    logic signed [DATA_W-1:0] divisor;
  } fdm_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] quotient;
    logic signed [DATA_W-1:0] modulo;
    logic                     divide_by_zero;
  } fdm_rsp_t;

  // control bits travelling alongside the magnitudes
  typedef struct packed {
    logic valid;
    logic a_neg;
    logic b_neg;
    logic div_zero;
  } fdm_ctl_t;

endpackage : fdm_pkg

// ----- hdl/fdm_prep.sv -----
// ----------------------------------------------------------------------------
// fdm_prep
// Entry stage: takes operand signs and magnitudes, flags a zero divisor.
// ----------------------------------------------------------------------------
module fdm_prep import fdm_pkg::*; #(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             req_valid_i,
  input  fdm_req_t         req_i,
  output fdm_ctl_t         ctl_o,
  output logic [WIDTH-1:0] ua_o,
  output logic [WIDTH-1:0] ub_o
);

  logic [WIDTH-1:0] a, b;
  logic [WIDTH-1:0] ua_d, ub_d, ua_q, ub_q;
  fdm_ctl_t         ctl_d, ctl_q;

  always_comb begin
    a              = req_i.dividend[WIDTH-1:0];
    b              = req_i.divisor[WIDTH-1:0];
    ua_d           = a[WIDTH-1] ? (-a) : a;
    ub_d           = b[WIDTH-1] ? (-b) : b;
    ctl_d.valid    = req_valid_i;
    ctl_d.a_neg    = a[WIDTH-1];
    ctl_d.b_neg    = b[WIDTH-1];
    ctl_d.div_zero = (b == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ua_q <= ua_d;
      ub_q <= ub_d;
    end
  end

  assign ctl_o = ctl_q;
  assign ua_o  = ua_q;
  assign ub_o  = ub_q;

endmodule : fdm_prep

// ----- hdl/fdm_div_step.sv -----
// ----------------------------------------------------------------------------
// fdm_div_step
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
module fdm_div_step import fdm_pkg::*; #(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  fdm_ctl_t         ctl_i,
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] quo_i,
  input  logic [WIDTH-1:0] dvs_i,
  output fdm_ctl_t         ctl_o,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH-1:0] quo_o,
  output logic [WIDTH-1:0] dvs_o
);

  logic [WIDTH:0]   cand;
  logic [WIDTH+1:0] diff;
  logic             fits;
  logic [WIDTH-1:0] rem_d, quo_d, rem_q, quo_q, dvs_q;
  fdm_ctl_t         ctl_q;

  always_comb begin
    cand  = {rem_i, quo_i[WIDTH-1]};
    // top bit of diff is the borrow
    diff  = {1'b0, cand} - {2'b00, dvs_i};
    fits  = ~diff[WIDTH+1];
    rem_d = fits ? diff[WIDTH-1:0] : cand[WIDTH-1:0];
    quo_d = {quo_i[WIDTH-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      dvs_q <= dvs_i;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign dvs_o = dvs_q;

endmodule : fdm_div_step

// ----- hdl/fdm_post.sv -----
// ----------------------------------------------------------------------------
// fdm_post
// Exit stage: floors the truncated result and holds the output register.
// ----------------------------------------------------------------------------
module fdm_post import fdm_pkg::*; #(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  fdm_ctl_t         ctl_i,
  input  logic [WIDTH-1:0] qmag_i,
  input  logic [WIDTH-1:0] rmag_i,
  input  logic [WIDTH-1:0] ub_i,
  output logic             rsp_valid_o,
  output fdm_rsp_t         rsp_o
);

  logic [WIDTH-1:0] q_w, r_w, r_diff;
  logic             r_nz;
  fdm_rsp_t         rsp_d, rsp_q;
  logic             valid_q;

  always_comb begin
    r_nz   = (rmag_i != '0);
    r_diff = ctl_i.b_neg ? (rmag_i - ub_i) : (ub_i - rmag_i);
    if (ctl_i.div_zero) begin
      q_w = '0;
      r_w = '0;
    end else if (ctl_i.a_neg == ctl_i.b_neg) begin
      q_w = qmag_i;
      r_w = ctl_i.a_neg ? (-rmag_i) : rmag_i;
    end else begin
      // -(q + 1) is ~q
      q_w = r_nz ? ~qmag_i : (-qmag_i);
      r_w = r_nz ? r_diff : '0;
    end
    rsp_d.quotient       = DATA_W'(signed'(q_w));
    rsp_d.modulo         = DATA_W'(signed'(r_w));
    rsp_d.divide_by_zero = ctl_i.div_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = valid_q;
  assign rsp_o       = rsp_q;

endmodule : fdm_post

// ----- hdl/floored_divide_modulo_core.sv -----
// ----------------------------------------------------------------------------
// floored_divide_modulo_core
// Pipelined signed division giving floored quotient and modulo.
// ----------------------------------------------------------------------------
// The core accepts one request per clock while the output is not stalled and
// returns one response per request, in order: the entry stage takes operand
// magnitudes, each fdm_div_step stage of the chain runs one restoring
// division step, and the exit stage floors the result into the output
// register. The quotient rounds towards negative infinity and the modulo
// takes the sign of the divisor. A zero divisor sets divide_by_zero and
// returns zero for both values; the most negative value over minus one
// wraps. Only the low WIDTH bits of each operand are used and results are
// sign-extended from bit WIDTH-1. A stall on the response side freezes the
// whole pipeline, so nothing is lost or repeated; when the output register
// is empty the pipeline always moves.
module floored_divide_modulo_core import fdm_pkg::*; #(
  parameter int unsigned WIDTH = WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  // request channel
  input  logic     req_valid_i,
  output logic     req_stall_o,
  input  fdm_req_t req_i,
  // response channel
  output logic     rsp_valid_o,
  input  logic     rsp_stall_i,
  output fdm_rsp_t rsp_o
);

  // whole pipeline moves together, held only by a stalled full output
  logic adv;

  // stage signals, index 0 is the entry stage output
  fdm_ctl_t         ctl_s [WIDTH+1];
  logic [WIDTH-1:0] rem_s [WIDTH+1];
  logic [WIDTH-1:0] quo_s [WIDTH+1];
  logic [WIDTH-1:0] dvs_s [WIDTH+1];

  assign adv         = !rsp_valid_o || !rsp_stall_i;
  assign req_stall_o = !adv;

  // magnitudes and signs
  fdm_prep #(
    .WIDTH (WIDTH)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .req_valid_i (req_valid_i),
    .req_i       (req_i),
    .ctl_o       (ctl_s[0]),
    .ua_o        (quo_s[0]),
    .ub_o        (dvs_s[0])
  );

  // partial remainder starts empty
  assign rem_s[0] = '0;

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < WIDTH; i++) begin : g_step
    fdm_div_step #(
      .WIDTH (WIDTH)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .ctl_i  (ctl_s[i]),
      .rem_i  (rem_s[i]),
      .quo_i  (quo_s[i]),
      .dvs_i  (dvs_s[i]),
      .ctl_o  (ctl_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .quo_o  (quo_s[i+1]),
      .dvs_o  (dvs_s[i+1])
    );
  end

  // flooring correction and output register
  fdm_post #(
    .WIDTH (WIDTH)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctl_i       (ctl_s[WIDTH]),
    .qmag_i      (quo_s[WIDTH]),
    .rmag_i      (rem_s[WIDTH]),
    .ub_i        (dvs_s[WIDTH]),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

`ifndef ASSERT_OFF
  // an empty output register never holds back the pipeline
  a_no_idle_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_o |-> !req_stall_o)
    else $error("pipeline stalled with empty output");

  // an accepted request enters the entry stage
  a_req_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && !req_stall_o) |=> ctl_s[0].valid)
    else $error("accepted request lost at entry");

  // zero divisor forces both values to zero
  a_dz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.divide_by_zero) |->
      (rsp_o.quotient == '0 && rsp_o.modulo == '0))
    else $error("divide by zero with nonzero result");

  // results are sign-extended from the operand width
  a_sign_ext : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |->
      (rsp_o.quotient[DATA_W-1:WIDTH-1] ==
         {(DATA_W-WIDTH+1){rsp_o.quotient[WIDTH-1]}} &&
       rsp_o.modulo[DATA_W-1:WIDTH-1] ==
         {(DATA_W-WIDTH+1){rsp_o.modulo[WIDTH-1]}}))
    else $error("result not sign-extended");
`endif

endmodule : floored_divide_modulo_core

// ----- tb/sv/floored_divide_modulo_core_tb.sv -----
// ----------------------------------------------------------------------------
// floored_divide_modulo_core_tb
// Self-checking bench for the floored divide / modulo core. A queue of
// operand pairs, directed corner cases first and then random ones, feeds a
// clocked driver. A clocked monitor compares every response against a
// floored division worked out in the bench when the request was accepted.
// ----------------------------------------------------------------------------
module floored_divide_modulo_core_tb;
  import fdm_pkg::*;

  // operand width of the instance, the arithmetic below follows it
  localparam int unsigned OP_W        = WIDTH_DEF;
  localparam int unsigned N_RANDOM    = 950;
  // pipeline depth is OP_W + 2, the tail wait covers it a few times
  localparam int unsigned TAIL_CYCLES = 3 * (OP_W + 2);
  // one long receiver hold-off, entered after this many responses
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned HOLD_LEN    = 400;
  // requests in this window go in back to back so the core fills up
  localparam int unsigned BURST_LO    = 100;
  localparam int unsigned BURST_HI    = 520;

  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] MINUS_1  = 64'hffff_ffff_ffff_ffff;

  typedef struct {
    fdm_req_t    operands;
    int unsigned gap;       // idle cycles before the next request
  } div_item_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     req_valid = 1'b0;
  logic     req_stall;
  fdm_req_t req_data = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  fdm_rsp_t rsp_data;

  div_item_t   pending_divs[$];
  fdm_rsp_t    awaiting_results[$];
  int unsigned div_errors = 0;

  floored_divide_modulo_core #(
    .WIDTH(OP_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_stall_o(req_stall),
    .req_i      (req_data),
    .rsp_valid_o(rsp_valid),
    .rsp_stall_i(rsp_stall),
    .rsp_o      (rsp_data)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // floored division worked out on unsigned magnitudes
  // --------------------------------------------------------------------------

  // keep the low OP_W bits and sign-extend from bit OP_W-1
  function automatic logic [63:0] sext_op(logic [63:0] v);
    logic [63:0] keep;
    keep = (OP_W >= 64) ? '1 : ((64'd1 << OP_W) - 64'd1);
    v = v & keep;
    if (v[OP_W-1]) begin
      v = v | ~keep;
    end
    return v;
  endfunction

  function automatic fdm_rsp_t floor_divmod(fdm_req_t op);
    logic [63:0] a, b, ua, ub, qmag, rmag, q, m;
    logic        a_neg, b_neg;
    fdm_rsp_t    res;
    a     = sext_op(op.dividend);
    b     = sext_op(op.divisor);
    a_neg = a[63];
    b_neg = b[63];
    // the most negative value negates to itself, which reads fine unsigned
    ua    = a_neg ? -a : a;
    ub    = b_neg ? -b : b;
    q     = '0;
    m     = '0;
    res.divide_by_zero = (ub == 64'd0);
    if (ub != 64'd0) begin
      qmag = ua / ub;
      rmag = ua % ub;
      if (a_neg == b_neg || ua == 64'd0) begin
        // same signs or zero dividend: truncation already floors, remainder follows dividend
        q = qmag;
        m = a_neg ? -rmag : rmag;
      end else begin
        // signs differ: round the magnitude up, remainder moves to divisor side
        q = -(qmag + ((rmag != 64'd0) ? 64'd1 : 64'd0));
        m = (rmag != 64'd0) ? (ub - rmag) : 64'd0;
        if (b_neg) begin
          m = -m;
        end
      end
    end
    res.quotient = sext_op(q);
    res.modulo   = sext_op(m);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  task automatic queue_div(logic [63:0] a, logic [63:0] b, int unsigned gap);
    div_item_t it;
    it.operands.dividend = a;
    it.operands.divisor  = b;
    it.gap               = gap;
    pending_divs.push_back(it);
  endtask

  // mix of operand shapes: full random, small, short magnitudes and extremes
  function automatic logic [63:0] random_operand();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0, 1, 2: v = {$urandom, $urandom};
      3:       v = 64'($signed($urandom_range(0, 40)) - 20);
      4: begin
        case ($urandom_range(0, 4))
          0:       v = MOST_NEG;
          1:       v = MOST_POS;
          2:       v = MINUS_1;
          3:       v = 64'd1;
          default: v = MOST_NEG + 64'($urandom_range(1, 3));
        endcase
      end
      default: begin
        // random bit length, random sign
        v = {$urandom, $urandom} >> $urandom_range(1, 63);
        if ($urandom_range(0, 1)) begin
          v = -v;
        end
      end
    endcase
    return v;
  endfunction

  function automatic int unsigned draw_gap(int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 14);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // request driver: pops one pending item at a time, predicts on acceptance
  // --------------------------------------------------------------------------
  int unsigned drv_gap;
  int unsigned drv_next_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    logic valid_nxt;
    if (!rst_ni) begin
      req_valid    <= 1'b0;
      req_data     <= '0;
      drv_gap      = 0;
      drv_next_gap = 0;
    end else begin
      valid_nxt = req_valid;
      if (req_valid && !req_stall) begin
        awaiting_results.push_back(floor_divmod(req_data));
        drv_gap   = drv_next_gap;
        valid_nxt = 1'b0;
      end
      // a stalled request keeps its payload and its valid
      if (!valid_nxt) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_divs.size() > 0) begin
          div_item_t it;
          it           = pending_divs.pop_front();
          req_data     <= it.operands;
          drv_next_gap = it.gap;
          valid_nxt    = 1'b1;
        end
      end
      req_valid <= valid_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // response monitor: stalls at random, compares each response in order
  // --------------------------------------------------------------------------
  int unsigned rsp_seen;
  int unsigned rsp_wait;
  int unsigned rsp_hold;
  int unsigned rsp_mode;
  bit          hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    fdm_rsp_t want;
    logic     stall_nxt;
    if (!rst_ni) begin
      rsp_stall <= 1'b0;
      rsp_seen  = 0;
      rsp_wait  = 0;
      rsp_hold  = 0;
      rsp_mode  = 0;
      hold_done = 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaiting_results.size() == 0) begin
          $display("%0t: response with none outstanding: q=%h m=%h dz=%b", $time,
                   rsp_data.quotient, rsp_data.modulo, rsp_data.divide_by_zero);
          div_errors++;
        end else begin
          want = awaiting_results.pop_front();
          if (rsp_data.quotient !== want.quotient) begin
            $display("%0t: quotient expected %h actual %h", $time,
                     want.quotient, rsp_data.quotient);
            div_errors++;
          end
          if (rsp_data.modulo !== want.modulo) begin
            $display("%0t: modulo expected %h actual %h", $time,
                     want.modulo, rsp_data.modulo);
            div_errors++;
          end
          if (rsp_data.divide_by_zero !== want.divide_by_zero) begin
            $display("%0t: divide_by_zero expected %b actual %b", $time,
                     want.divide_by_zero, rsp_data.divide_by_zero);
            div_errors++;
          end
        end
        rsp_seen++;
        // change idling style every so often, stretches with none included
        if (rsp_seen % 64 == 0) begin
          rsp_mode = $urandom_range(0, 2);
        end
        rsp_wait = draw_gap(rsp_mode);
        // one long hold-off while the sender keeps pushing
        if (rsp_seen == HOLD_AT && !hold_done) begin
          rsp_hold  = HOLD_LEN;
          hold_done = 1'b1;
        end
      end
      stall_nxt = 1'b0;
      if (rsp_hold > 0) begin
        rsp_hold--;
        stall_nxt = 1'b1;
      end else if (rsp_wait > 0) begin
        rsp_wait--;
        stall_nxt = 1'b1;
      end
      rsp_stall <= stall_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap_mode;
    int unsigned n;
    logic [63:0] a, b;

    // directed: zero divisor, every sign pairing, wrap case and extremes
    queue_div(64'd0, 64'd0, 0);
    queue_div(64'd5, 64'd0, 1);
    queue_div(MOST_NEG, 64'd0, 0);
    queue_div(64'd7, 64'd2, 0);
    queue_div(-64'd7, 64'd2, 2);
    queue_div(64'd7, -64'd2, 0);
    queue_div(-64'd7, -64'd2, 0);
    queue_div(64'd6, 64'd3, 0);
    queue_div(-64'd6, 64'd3, 3);
    queue_div(64'd6, -64'd3, 0);
    queue_div(64'd0, -64'd5, 0);
    queue_div(MOST_NEG, MINUS_1, 0);
    queue_div(MOST_NEG, 64'd1, 1);
    queue_div(MOST_POS, MINUS_1, 0);
    queue_div(MOST_POS, MOST_POS, 0);
    queue_div(MOST_NEG, MOST_NEG, 0);
    queue_div(MOST_NEG, MOST_POS, 4);
    queue_div(MOST_POS, MOST_NEG, 0);
    queue_div(MINUS_1, MOST_NEG, 0);
    queue_div(64'd1, MOST_NEG, 0);
    queue_div(64'd1, MINUS_1, 0);
    queue_div(MINUS_1, 64'd1, 0);
    queue_div(MOST_POS, 64'd2, 0);
    queue_div(MOST_NEG, 64'd3, 0);

    gap_mode = 1;
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i % 40 == 0) begin
        gap_mode = $urandom_range(0, 2);
      end
      a = random_operand();
      case ($urandom_range(0, 9))
        0:       b = 64'd0;
        1:       b = $urandom_range(0, 1) ? MINUS_1 : 64'd1;
        2: begin
          // exact multiple, so the remainder is zero on either sign pairing
          b = random_operand();
          n = $urandom_range(0, 1000);
          a = b * 64'($signed(n) - 500);
        end
        default: b = random_operand();
      endcase
      n = pending_divs.size();
      queue_div(a, b, (n >= BURST_LO && n < BURST_HI) ? 0 : draw_gap(gap_mode));
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: nothing left to send and nothing outstanding
    while (pending_divs.size() != 0 || req_valid || awaiting_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    // every accepted request must have come back
    if (awaiting_results.size() != 0) begin
      $display("%0t: responses outstanding expected 0 actual %0d", $time,
               awaiting_results.size());
      div_errors++;
    end

    if (div_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // generous bound on the whole run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule : floored_divide_modulo_core_tb
